// ===== hw/rtl/msbv_pkg.sv =====
// ----------------------------------------------------------------------------
// msbv_pkg
// Shared constants, tables and command types of the metallic square-bank
// voice: voice count, fixed oscillator increments, reciprocal table,
// register indexes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msbv_pkg;

  localparam int SAMPLE_RATE_HZ = 48000;
  localparam int VOICES         = 6;
  localparam int VIDX_W         = $clog2(VOICES);

  localparam int STEP_W   = 31;
  localparam int PHASE_W  = 32;
  localparam int PITCH_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int COUNT_W  = 3;
  localparam int POLE_W   = 16;
  localparam int SAMPLE_W = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLE        = 3'd4;

  // Reset values of the registers.
  localparam logic [STEP_W-1:0]  RST_FIRST_STEP  = 31'd48318382;
  localparam logic [STEP_W-1:0]  RST_SECOND_STEP = 31'd71582788;
  localparam logic [GAIN_W-1:0]  RST_GAIN        = 16'd32768;
  localparam logic [COUNT_W-1:0] RST_COUNT       = 3'd6;
  localparam logic [POLE_W-1:0]  RST_POLE        = 16'd65470;

  localparam logic [PHASE_W-1:0] HALF_PHASE = 32'h8000_0000;

  // Fixed increments of the four untuned voices, in tenths of a hertz,
  // rounded to nearest at the sample rate.
  localparam logic [63:0] STEP_DEN  = 64'(10 * SAMPLE_RATE_HZ);
  localparam logic [63:0] STEP_BIAS = 64'(5 * SAMPLE_RATE_HZ);
  localparam logic [STEP_W-1:0] FIXED_STEP_0 =
    STEP_W'(((64'(2053) << 32) + STEP_BIAS) / STEP_DEN);
  localparam logic [STEP_W-1:0] FIXED_STEP_1 =
    STEP_W'(((64'(3696) << 32) + STEP_BIAS) / STEP_DEN);
  localparam logic [STEP_W-1:0] FIXED_STEP_2 =
    STEP_W'(((64'(4044) << 32) + STEP_BIAS) / STEP_DEN);
  localparam logic [STEP_W-1:0] FIXED_STEP_3 =
    STEP_W'(((64'(5227) << 32) + STEP_BIAS) / STEP_DEN);

  // Base increment of a voice with a fixed pitch (voices two and up).
  function automatic logic [STEP_W-1:0] fixed_step(input logic [VIDX_W-1:0] idx);
    logic [VIDX_W-1:0] k;
    logic [STEP_W-1:0] r;
    k = idx - VIDX_W'(2);
    unique case (k[1:0])
      2'd0:    r = FIXED_STEP_0;
      2'd1:    r = FIXED_STEP_1;
      2'd2:    r = FIXED_STEP_2;
      default: r = FIXED_STEP_3;
    endcase
    return r;
  endfunction

  // round(2^16 / n) for the active voice count.
  function automatic logic [GAIN_W-1:0] recip_q16(input logic [COUNT_W-1:0] n);
    logic [GAIN_W-1:0] r;
    unique case (n)
      3'd2:    r = 16'd32768;
      3'd3:    r = 16'd21845;
      3'd4:    r = 16'd16384;
      3'd5:    r = 16'd13107;
      3'd6:    r = 16'd10923;
      3'd7:    r = 16'd9362;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // Clamps the programmed voice count into two through VOICES.
  function automatic logic [COUNT_W-1:0] voice_limit(input logic [COUNT_W-1:0] vc);
    logic [COUNT_W-1:0] r;
    if (vc < COUNT_W'(2)) begin
      r = COUNT_W'(2);
    end else if (vc > COUNT_W'(VOICES)) begin
      r = COUNT_W'(VOICES);
    end else begin
      r = vc;
    end
    return r;
  endfunction

  // One command per cycle from the sequencer to the datapath.
  typedef struct packed {
    logic              start;   // latch pitch, clear the sum
    logic              mul;     // base increment times pitch
    logic              acc;     // advance the phase, accumulate the sign
    logic              gain;    // sum times gain, pole times last output
    logic              scale;   // scaled sum times reciprocal
    logic              round;   // round and clamp the scaled sum
    logic              commit;  // DC blocker output into the sample register
    logic [VIDX_W-1:0] voice;
  } msbv_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/msbv_datapath.sv =====
// ----------------------------------------------------------------------------
// msbv_datapath
// Phase accumulators, one shared step multiplier, the gain and reciprocal
// scaling and the DC blocker, driven step by step by the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msbv_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  msbv_pkg::msbv_cmd_t           cmd_i,
  input  logic [msbv_pkg::PITCH_W-1:0]  pitch_scale_i,
  input  logic [msbv_pkg::STEP_W-1:0]   first_step_i,
  input  logic [msbv_pkg::STEP_W-1:0]   second_step_i,
  input  logic [msbv_pkg::GAIN_W-1:0]   gain_i,
  input  logic [msbv_pkg::COUNT_W-1:0]  voice_num_i,
  input  logic [msbv_pkg::POLE_W-1:0]   pole_i,
  output logic [msbv_pkg::SAMPLE_W-1:0] sample_o
);

  localparam int PROD_W = msbv_pkg::STEP_W + msbv_pkg::PITCH_W;

  logic [msbv_pkg::PITCH_W-1:0]  pitch_q;
  logic [PROD_W-1:0]             prod_q, prod_d;
  logic [msbv_pkg::PHASE_W-1:0]  phase_q [msbv_pkg::VOICES];
  logic signed [3:0]             sum_q, sum_d;
  logic signed [20:0]            gs_q, gs_d;
  logic signed [32:0]            fb_q, fb_d;
  logic signed [37:0]            xs_q, xs_d;
  logic signed [16:0]            x_q, x_d;
  logic signed [16:0]            xlast_q;
  logic signed [15:0]            ylast_q;
  logic [msbv_pkg::SAMPLE_W-1:0] sample_q;

  logic [msbv_pkg::STEP_W-1:0]  base_step;
  logic [msbv_pkg::STEP_W-1:0]  step_sat;
  logic [msbv_pkg::PHASE_W-1:0] phase_cur, phase_next;
  logic signed [20:0]           sum_ext, gain_ext;
  logic signed [32:0]           pole_ext, ylast_ext;
  logic signed [37:0]           gs_ext, recip_ext, xs_rnd;
  logic signed [21:0]           xs_flr;
  logic signed [32:0]           fb_rnd;
  logic signed [16:0]           fb_flr;
  logic signed [18:0]           y_sum;
  logic signed [15:0]           y_sat;

  // Voice stage: one multiply per voice, then the phase update.
  always_comb begin
    if (cmd_i.voice == '0) begin
      base_step = first_step_i;
    end else if (cmd_i.voice == msbv_pkg::VIDX_W'(1)) begin
      base_step = second_step_i;
    end else begin
      base_step = msbv_pkg::fixed_step(cmd_i.voice);
    end
  end

  assign prod_d     = PROD_W'(base_step) * PROD_W'(pitch_q);
  assign step_sat   = (|prod_q[PROD_W-1:43]) ? '1 : prod_q[42:12];
  assign phase_cur  = phase_q[cmd_i.voice];
  assign phase_next = phase_cur + {1'b0, step_sat};
  assign sum_d      = phase_cur[msbv_pkg::PHASE_W-1] ? (sum_q - 4'sd1) : (sum_q + 4'sd1);

  // Scaling: sum times gain, then times round(2^16 / n).
  assign sum_ext   = 21'(sum_q);
  assign gain_ext  = 21'($signed({1'b0, gain_i}));
  assign gs_d      = sum_ext * gain_ext;
  assign gs_ext    = 38'(gs_q);
  assign recip_ext = 38'($signed({1'b0, msbv_pkg::recip_q16(voice_num_i)}));
  assign xs_d      = gs_ext * recip_ext;

  assign xs_rnd = xs_q + 38'sd32768;
  assign xs_flr = xs_rnd[37:16];

  always_comb begin
    if (xs_flr > 22'sd65535) begin
      x_d = 17'sd65535;
    end else if (xs_flr < -22'sd65536) begin
      x_d = -17'sd65536;
    end else begin
      x_d = xs_flr[16:0];
    end
  end

  // DC blocker feedback term and output.
  assign pole_ext  = 33'($signed({1'b0, pole_i}));
  assign ylast_ext = 33'(ylast_q);
  assign fb_d      = pole_ext * ylast_ext;
  assign fb_rnd    = fb_q + 33'sd32768;
  assign fb_flr    = fb_rnd[32:16];
  assign y_sum     = 19'(x_q) - 19'(xlast_q) + 19'(fb_flr);

  always_comb begin
    if (y_sum > 19'sd32767) begin
      y_sat = 16'sd32767;
    end else if (y_sum < -19'sd32768) begin
      y_sat = -16'sd32768;
    end else begin
      y_sat = y_sum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < msbv_pkg::VOICES; i++) begin
        phase_q[i] <= msbv_pkg::HALF_PHASE;
      end
      xlast_q <= '0;
      ylast_q <= '0;
    end else begin
      if (cmd_i.acc) begin
        phase_q[cmd_i.voice] <= phase_next;
      end
      if (cmd_i.commit) begin
        xlast_q <= x_q;
        ylast_q <= y_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pitch_q <= pitch_scale_i;
    end
    if (cmd_i.start) begin
      sum_q <= '0;
    end else if (cmd_i.acc) begin
      sum_q <= sum_d;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.gain) begin
      gs_q <= gs_d;
      fb_q <= fb_d;
    end
    if (cmd_i.scale) begin
      xs_q <= xs_d;
    end
    if (cmd_i.round) begin
      x_q <= x_d;
    end
    if (cmd_i.commit) begin
      sample_q <= y_sat;
    end
  end

  assign sample_o = sample_q;

endmodule

`default_nettype wire

// ===== hw/rtl/msbv_ctrl.sv =====
// ----------------------------------------------------------------------------
// msbv_ctrl
// Sequencer of the square-bank voice: walks the active voices, then the
// scaling and blocker steps, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msbv_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic [msbv_pkg::COUNT_W-1:0] voice_num_i,
  output msbv_pkg::msbv_cmd_t          cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_ACC    = 3'd2;
  localparam logic [2:0] S_GAIN   = 3'd3;
  localparam logic [2:0] S_SCALE  = 3'd4;
  localparam logic [2:0] S_ROUND  = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic [msbv_pkg::VIDX_W-1:0] voice_q, voice_d;
  logic                        out_valid_q, out_valid_d;
  logic [msbv_pkg::VIDX_W-1:0] last_voice;
  logic                        in_take;
  logic                        slot_free;

  assign last_voice = msbv_pkg::VIDX_W'(voice_num_i - msbv_pkg::COUNT_W'(1));
  assign in_take    = in_valid_i && (state_q == S_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    voice_d     = voice_q;
    cmd_o       = '0;
    cmd_o.voice = voice_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          cmd_o.start = 1'b1;
          voice_d     = '0;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (voice_q == last_voice) begin
          state_d = S_GAIN;
        end else begin
          voice_d = voice_q + msbv_pkg::VIDX_W'(1);
          state_d = S_MUL;
        end
      end
      S_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d    = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = S_COMMIT;
      end
      S_COMMIT: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      voice_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      voice_q     <= voice_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // A new result never overwrites one that is still waiting.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || !out_stall_i))
    else $error("result committed over a pending transaction");

  // An accepted transaction always starts with the first voice.
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_MUL && voice_q == '0))
    else $error("accepted transaction did not start at voice zero");

  // The voice walk never passes the last active voice.
  a_voice_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_ACC) |-> (voice_q <= last_voice))
    else $error("voice index beyond the active voice count");

  // Each commit shows up as a valid result in the next cycle.
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("committed result not presented");

endmodule

`default_nettype wire

// ===== hw/rtl/metallic_square_bank_voice.sv =====
// ----------------------------------------------------------------------------
// metallic_square_bank_voice
// Once an input transaction is accepted, each of the n active voices gets a
//   multiply and a phase update, n being the clamped voice count; then the
//   gain, scale and round steps and the commit to the output register follow.
//   A new input is taken only after the commit; voices share one multiplier.
// Reset: asynchronous, active low; phases return to one half, the DC blocker
//   history to zero and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module metallic_square_bank_voice (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input channel: one pitch scale per sample tick.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [msbv_pkg::PITCH_W-1:0]    pitch_scale_i,
  // Output channel: one audio sample per accepted tick.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [msbv_pkg::SAMPLE_W-1:0] sample_out_o,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [msbv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [msbv_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers. Writes are expected only while the block is
  // idle, so the datapath reads them directly without shadow copies.
  logic [msbv_pkg::STEP_W-1:0]  first_step_q;
  logic [msbv_pkg::STEP_W-1:0]  second_step_q;
  logic [msbv_pkg::GAIN_W-1:0]  gain_q;
  logic [msbv_pkg::COUNT_W-1:0] count_q;
  logic [msbv_pkg::POLE_W-1:0]  pole_q;
  logic [msbv_pkg::COUNT_W-1:0] voice_num;
  logic                         cfg_write;

  msbv_pkg::msbv_cmd_t          cmd;
  logic [msbv_pkg::SAMPLE_W-1:0] sample;

  // The register file can always take a transaction.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_step_q  <= msbv_pkg::RST_FIRST_STEP;
      second_step_q <= msbv_pkg::RST_SECOND_STEP;
      gain_q        <= msbv_pkg::RST_GAIN;
      count_q       <= msbv_pkg::RST_COUNT;
      pole_q        <= msbv_pkg::RST_POLE;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        msbv_pkg::REG_FIRST_STEP:  first_step_q  <= cfg_data_i[msbv_pkg::STEP_W-1:0];
        msbv_pkg::REG_SECOND_STEP: second_step_q <= cfg_data_i[msbv_pkg::STEP_W-1:0];
        msbv_pkg::REG_GAIN:        gain_q        <= cfg_data_i[msbv_pkg::GAIN_W-1:0];
        msbv_pkg::REG_COUNT:       count_q       <= cfg_data_i[msbv_pkg::COUNT_W-1:0];
        msbv_pkg::REG_POLE:        pole_q        <= cfg_data_i[msbv_pkg::POLE_W-1:0];
        default: begin
          // Indexes past the register list are dropped.
        end
      endcase
    end
  end

  // A programmed count below two runs two voices; one above the bank size
  // runs the whole bank. Both the sequencer and the reciprocal use it.
  assign voice_num = msbv_pkg::voice_limit(count_q);

  // The sequencer steps through the active voices one multiply and one
  // phase update at a time, then through gain scaling, rounding and the
  // DC blocker, and finally holds until the output register is free.
  msbv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .voice_num_i (voice_num),
    .cmd_o       (cmd)
  );

  // The datapath holds the phases, the blocker history and the output
  // register, so a finished sample can wait while the next tick is taken.
  msbv_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .pitch_scale_i (pitch_scale_i),
    .first_step_i  (first_step_q),
    .second_step_i (second_step_q),
    .gain_i        (gain_q),
    .voice_num_i   (voice_num),
    .pole_i        (pole_q),
    .sample_o      (sample)
  );

  assign sample_out_o = $signed(sample);

endmodule

`default_nettype wire
